// ----- rtl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the text pattern search unit
// Request codes, configuration register indexes, the per-cell control word
// and the ASCII letter folding function.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam logic [1:0] REQ_PATTERN = 2'd0;
  localparam logic [1:0] REQ_TEXT    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] CFG_CASE_FOLD      = 2'd1;
  localparam logic [1:0] CFG_REVERSE_MODE   = 2'd2;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       step;
    logic       clear;
    logic       case_fold;
    logic [7:0] text_byte;
  } tps_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
    logic [7:0] r;
    r = b;
    if (fold && (b inside {[8'h41:8'h5A]})) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- rtl/tps_cell.sv -----
// ----------------------------------------------------------------------------
// tps_cell: one position of the match chain
// Holds one pattern byte and one partial-match bit. The bit is taken from the
// neighbor below on every text word and qualified by the aligned compare.
// ----------------------------------------------------------------------------
module tps_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  tps_pkg::tps_ctrl_t ctrl,
  input  logic              pat_we,
  input  logic [7:0]        pat_data,
  input  logic              prev_bit,
  input  logic              eq_in,
  output logic              eq_out,
  output logic              match_bit,
  output logic              match_nxt
);
  import tps_pkg::*;

  logic [7:0] pat_r;
  logic       bit_r;
  logic       bit_nxt;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r <= pat_data;
    end
  end

  assign eq_out    = (fold_byte(pat_r, ctrl.case_fold) == ctrl.text_byte);
  assign match_nxt = prev_bit & eq_in;

  always_comb begin
    bit_nxt = bit_r;
    if (ctrl.clear) begin
      bit_nxt = 1'b0;
    end else if (ctrl.step) begin
      bit_nxt = match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  assign match_bit = bit_r;

endmodule

// ----- rtl/tps_align.sv -----
// ----------------------------------------------------------------------------
// tps_align: compare alignment network
// Maps the per-cell compare results onto chain positions. Forward mode keeps
// the order; reverse mode mirrors the first pattern_length entries.
// ----------------------------------------------------------------------------
module tps_align #(
  parameter int PATTERN_MAX = 64,
  localparam int LW = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX-1:0] eq_phys,
  input  logic [LW-1:0]          used_len,
  input  logic                   reverse,
  output logic [PATTERN_MAX-1:0] eq_chain
);
  logic [PATTERN_MAX-1:0] mask;
  logic [PATTERN_MAX-1:0] mirrored;
  logic [PATTERN_MAX-1:0] shifted;
  logic [LW-1:0]          shift_amt;

  for (genvar u = 0; u < PATTERN_MAX; u++) begin : g_pos
    assign mask[u]     = (u < int'(used_len));
    assign mirrored[u] = eq_phys[PATTERN_MAX-1-u];
  end

  assign shift_amt = LW'(PATTERN_MAX) - used_len;
  assign shifted   = mirrored >> shift_amt;
  assign eq_chain  = reverse ? (shifted & mask) : (eq_phys & mask);

endmodule

// ----- rtl/text_pattern_search_unit.sv -----
// ----------------------------------------------------------------------------
// text_pattern_search_unit: streaming substring matcher
// Each accepted input word yields a registered result word, valid in the cycle after.
// Throughput: one word per cycle while no result is pending or out_ready is high; the
// match chain advances by one cell per text word; the result register frees as taken.
// Reset: synchronous, active low; clears the chain, counter and found flag and
// returns config registers to defaults; pattern bytes are undefined until written.
// ----------------------------------------------------------------------------
module text_pattern_search_unit #(
  parameter int PATTERN_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_pattern_index,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_match_found,
  output logic [31:0] out_match_position,
  output logic        out_already_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import tps_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int IW = $clog2(PATTERN_MAX);

  logic [6:0]             len_r;
  logic                   fold_r;
  logic                   rev_r;
  logic [31:0]            cnt_r;
  logic [31:0]            cnt_nxt;
  logic                   found_r;
  logic                   found_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   match_r;
  logic [31:0]            pos_r;
  logic                   already_r;
  logic                   in_acc;
  logic                   is_text;
  logic                   is_restart;
  logic                   is_pattern;
  logic                   hit;
  logic [LW-1:0]          used_len;
  logic [IW-1:0]          top_sel;
  tps_ctrl_t              ctrl;
  logic [PATTERN_MAX-1:0] eq_phys;
  logic [PATTERN_MAX-1:0] eq_chain;
  logic [PATTERN_MAX-1:0] chain_bit;
  logic [PATTERN_MAX-1:0] chain_nxt;

  assign in_ready   = !out_valid_r || out_ready;
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_valid && in_ready;
  assign is_text    = in_acc && (in_req_type == REQ_TEXT);
  assign is_restart = in_acc && (in_req_type == REQ_RESTART);
  assign is_pattern = in_acc && (in_req_type == REQ_PATTERN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= 7'd0;
      fold_r <= 1'b1;
      rev_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: len_r  <= cfg_data;
        CFG_CASE_FOLD:      fold_r <= cfg_data[0];
        CFG_REVERSE_MODE:   rev_r  <= cfg_data[0];
        default:            len_r  <= len_r;
      endcase
    end
  end

  assign used_len = (int'(len_r) > PATTERN_MAX) ? LW'(PATTERN_MAX) : LW'(len_r);
  assign top_sel  = IW'(used_len - LW'(1));

  assign ctrl.step      = is_text;
  assign ctrl.clear     = is_restart;
  assign ctrl.case_fold = fold_r;
  assign ctrl.text_byte = fold_byte(in_data_byte, fold_r);

  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_cell
    logic prev_bit;
    if (p == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_link
      assign prev_bit = chain_bit[p-1];
    end
    tps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .pat_we    (is_pattern && (int'(in_pattern_index) == p)),
      .pat_data  (in_data_byte),
      .prev_bit  (prev_bit),
      .eq_in     (eq_chain[p]),
      .eq_out    (eq_phys[p]),
      .match_bit (chain_bit[p]),
      .match_nxt (chain_nxt[p])
    );
  end

  tps_align #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_align (
    .eq_phys  (eq_phys),
    .used_len (used_len),
    .reverse  (rev_r),
    .eq_chain (eq_chain)
  );

  assign hit = is_text && (used_len != '0) && chain_nxt[top_sel] && !found_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    if (is_restart) begin
      cnt_nxt   = 32'd0;
      found_nxt = 1'b0;
    end else if (is_text) begin
      if (cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + 32'd1;
      end
      if (hit) begin
        found_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 32'd0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      match_r   <= hit;
      pos_r     <= cnt_nxt;
      already_r <= found_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_match_found    = match_r;
  assign out_match_position = pos_r;
  assign out_already_found  = already_r;

endmodule

// ----- rtl/tps_checker.sv -----
// ----------------------------------------------------------------------------
// tps_checker: port-level checks of the text pattern search unit
// Watches the top-level channels; flags result words that break the handshake
// or disagree with their requests, and input stalls while out_valid is low.
// ----------------------------------------------------------------------------
module tps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_match_found,
  input logic [31:0] out_match_position,
  input logic        out_already_found
);
  import tps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_found) &&
    $stable(out_match_position) && $stable(out_already_found))
    else $error("Result word changed while stalled.");

  a_found_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_found |-> out_already_found && (out_match_position != 32'd0))
    else $error("Match reported without found flag or position.");

  a_restart_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_RESTART) |=>
    out_valid && (out_match_position == 32'd0) && !out_already_found && !out_match_found)
    else $error("Restart word did not clear the scan state.");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled with an empty result register.");

endmodule

bind text_pattern_search_unit tps_checker u_tps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_req_type        (in_req_type),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_match_found    (out_match_found),
  .out_match_position (out_match_position),
  .out_already_found  (out_already_found)
);
